// ----- src/lfuda_pkg.sv -----
// Shared types, constants and control structs of the LFUDA replacement block.
package lfuda_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int PRIO_BITS_DEF = 32;
    localparam int KEY_W         = 64;
    localparam int STAMP_W       = 32;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_LEVEL,
        ST_WRITE
    } ctl_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic decide;
        logic level;
        logic write;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic need_level;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- src/lfuda_ram.sv -----
// Generic single write port RAM with registered read.
module lfuda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/lfuda_ctrl.sv -----
// Sequencing state machine of the LFUDA replacement block.
module lfuda_ctrl
    import lfuda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_level ? ST_LEVEL : ST_WRITE;
            end
            ST_LEVEL:
            begin
                cmd.level = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- src/lfuda_dp.sv -----
// Datapath of the LFUDA replacement block: slot memory, scan accumulators, result register.
module lfuda_dp
    import lfuda_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_cmd_t  cmd,
    output dp_sts_t   sts,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int P  = PRIO_BITS;
    localparam int W  = 1 + KEY_W + P + STAMP_W;
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

    function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [P-1:0] b);
        logic [P:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[P] ? {P{1'b1}} : s[P-1:0];
    endfunction

    // Scan control
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_issue;

    // Request and global state
    logic             act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [P-1:0]     lvl_reg, lvl_next;
    logic [STAMP_W-1:0] sc_reg;

    // First scan
    logic               found_reg;
    logic [IW-1:0]      found_idx_reg;
    logic [P-1:0]       found_prio_reg;
    logic               free_reg;
    logic [IW-1:0]      free_idx_reg;
    logic               vic_any_reg;
    logic [IW-1:0]      vic_idx_reg;
    logic [P-1:0]       vic_prio_reg;
    logic [STAMP_W-1:0] vic_age_reg;
    logic [KEY_W-1:0]   vic_key_reg;

    // Decision
    logic          chk_reg;
    logic [IW-1:0] x_idx_reg;
    logic          wr_en_reg;
    logic          wr_ins_reg;
    logic          wr_valid_reg;
    logic [IW-1:0] wr_slot_reg;
    logic [P-1:0]  wr_prio_reg;
    rsp_item_t     res_reg;

    // Second scan
    logic         eq_reg;
    logic         any2_reg;
    logic [P-1:0] min2_reg;

    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    // Memory
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [W-1:0]       ram_wdata;
    logic [W-1:0]       ram_rdata;
    logic               e_valid;
    logic [KEY_W-1:0]   e_key;
    logic [P-1:0]       e_prio;
    logic [STAMP_W-1:0] e_stamp;
    logic [STAMP_W-1:0] e_age;

    logic [P-1:0] hit_prio;
    logic         chk_c;
    logic [P-1:0] ins_prio;

    assign rd_issue = (cmd.scan || cmd.level) && (cnt_reg != CNT_END);
    assign {e_valid, e_key, e_prio, e_stamp} = ram_rdata;
    assign e_age    = sc_reg - e_stamp;
    assign hit_prio = sat_add(found_prio_reg, lvl_reg);

    // Whether the level must be searched again once this item leaves its priority.
    always_comb
    begin
        chk_c = 1'b0;
        priority if (act_reg == ACT_REMOVE)
        begin
            chk_c = found_reg && (found_prio_reg == lvl_reg);
        end
        else if (found_reg)
        begin
            chk_c = (hit_prio != found_prio_reg) && (found_prio_reg == lvl_reg);
        end
        else
        begin
            chk_c = !free_reg;
        end
    end

    always_comb
    begin
        lvl_next = lvl_reg;
        if (cmd.decide && act_reg == ACT_ACCESS && !found_reg && !free_reg)
        begin
            lvl_next = vic_prio_reg;
        end
        else if (cmd.write && chk_reg && !eq_reg && any2_reg)
        begin
            lvl_next = min2_reg;
        end
    end

    assign ins_prio = sat_add(lvl_next, P'(1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load || cmd.decide)
        begin
            cnt_next = '0;
        end
        else if (cmd.clear || rd_issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_slot_reg;
        ram_wdata = {wr_valid_reg, key_reg, wr_ins_reg ? ins_prio : wr_prio_reg, sc_reg};
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[IW-1:0];
            ram_wdata = '0;
        end
        else if (cmd.write)
        begin
            ram_we = wr_en_reg;
        end
    end

    lfuda_ram #(
        .WIDTH (W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_issue),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            lvl_reg       <= '0;
            sc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_issue;
            lvl_reg    <= lvl_next;
            if (cmd.write && wr_en_reg && wr_valid_reg)
            begin
                sc_reg <= sc_reg + STAMP_W'(1);
            end
            if (cmd.write)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[IW-1:0];
        if (cmd.load)
        begin
            act_reg     <= req.action;
            key_reg     <= req.key;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            vic_any_reg <= 1'b0;
        end
        if (cmd.scan && rd_vld_reg)
        begin
            if (e_valid && e_key == key_reg && !found_reg)
            begin
                found_reg      <= 1'b1;
                found_idx_reg  <= rd_idx_reg;
                found_prio_reg <= e_prio;
            end
            if (!e_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (e_valid && (!vic_any_reg || e_prio < vic_prio_reg
                            || (e_prio == vic_prio_reg && e_age > vic_age_reg)))
            begin
                vic_any_reg  <= 1'b1;
                vic_idx_reg  <= rd_idx_reg;
                vic_prio_reg <= e_prio;
                vic_age_reg  <= e_age;
                vic_key_reg  <= e_key;
            end
        end
        if (cmd.decide)
        begin
            chk_reg  <= chk_c;
            eq_reg   <= 1'b0;
            any2_reg <= 1'b0;
            priority if (act_reg == ACT_REMOVE)
            begin
                res_reg      <= '{found_reg, 1'b0, {KEY_W{1'b0}}};
                x_idx_reg    <= found_idx_reg;
                wr_en_reg    <= found_reg;
                wr_ins_reg   <= 1'b0;
                wr_valid_reg <= 1'b0;
                wr_slot_reg  <= found_idx_reg;
                wr_prio_reg  <= found_prio_reg;
            end
            else if (found_reg)
            begin
                res_reg      <= '{1'b1, 1'b0, {KEY_W{1'b0}}};
                x_idx_reg    <= found_idx_reg;
                wr_en_reg    <= 1'b1;
                wr_ins_reg   <= 1'b0;
                wr_valid_reg <= 1'b1;
                wr_slot_reg  <= found_idx_reg;
                wr_prio_reg  <= hit_prio;
            end
            else
            begin
                res_reg      <= '{1'b0, !free_reg, free_reg ? {KEY_W{1'b0}} : vic_key_reg};
                x_idx_reg    <= vic_idx_reg;
                wr_en_reg    <= 1'b1;
                wr_ins_reg   <= 1'b1;
                wr_valid_reg <= 1'b1;
                wr_slot_reg  <= free_reg ? free_idx_reg : vic_idx_reg;
                wr_prio_reg  <= found_prio_reg;
            end
        end
        if (cmd.level && rd_vld_reg && e_valid && rd_idx_reg != x_idx_reg)
        begin
            if (e_prio == lvl_reg)
            begin
                eq_reg <= 1'b1;
            end
            if (!any2_reg || e_prio < min2_reg)
            begin
                any2_reg <= 1'b1;
                min2_reg <= e_prio;
            end
        end
        if (cmd.write)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign sts.clr_last   = (cnt_reg[IW-1:0] == IDX_LAST);
    assign sts.scan_done  = (cnt_reg == CNT_END) && !rd_vld_reg;
    assign sts.need_level = chk_c;
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A new result appears only from a table update.
    a_rsp_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.write))
        else $error("result raised without a table update");

    // Hit and eviction never come together.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.hit && rsp_reg.evicted))
        else $error("hit and eviction in one result");

    // A result that evicts nothing carries a zero key.
    a_ekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.evicted) |-> (rsp_reg.evicted_key == '0))
        else $error("evicted key set without eviction");

    // Memory is never written while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.level) |-> !ram_we)
        else $error("slot write during scan");

endmodule

// ----- src/lfuda_replacement_policy.sv -----
// Top level of the LFUDA replacement block: controller and datapath.
//
//  Channel  | Signals                      | Direction | Item
//  request  | req_valid, req_stall, req    | in        | action, key
//  response | rsp_valid, rsp_stall, rsp    | out       | hit, evicted, evicted_key
//
// After reset the slot memory is cleared, during which req_stall is high.
// Each item goes from acceptance to its result through one pass over the
// slot memory, whose single read port delivers one slot a cycle, then a decision and
// an update. When the item leaves the group at the aging level, a second pass
// checks whether that group is now empty and finds the new level before the update.
// A finished result waits in the output register while the next item is accepted;
// the update of a following item waits only if that register is still stalled.
module lfuda_replacement_policy
    import lfuda_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    // Command and status links between the sequencer and the datapath.
    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // The sequencer walks the clear pass, the scans and the update.
    lfuda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the slot memory, the aging level and the result register.
    lfuda_dp #(
        .ENTRIES   (ENTRIES),
        .PRIO_BITS (PRIO_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- dv/lfuda_replacement_policy_test.sv -----
// Self-checking test of the LFUDA replacement block with a scoreboard and random traffic.
`timescale 1ns / 1ps

module lfuda_replacement_policy_test;
    import lfuda_pkg::*;

    localparam int NUM_SLOTS = ENTRIES_DEF;
    localparam logic [PRIO_BITS_DEF-1:0] PRIO_MAX = '1;
    localparam int STALL_LIMIT = 20000;

    // The scoreboard predicts the replacement decisions itself and keeps the
    // responses that the block still owes, oldest first.
    class lfuda_scoreboard;
        bit                     valid_q[NUM_SLOTS];
        logic [KEY_W-1:0]       key_q[NUM_SLOTS];
        logic [PRIO_BITS_DEF-1:0] prio_q[NUM_SLOTS];
        logic [STAMP_W-1:0]     stamp_q[NUM_SLOTS];
        logic [PRIO_BITS_DEF-1:0] level;
        logic [STAMP_W-1:0]     next_stamp;
        rsp_item_t              owed_rsp[$];
        int                     errors;

        function void clear_table();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                valid_q[i] = 0;
                key_q[i] = '0;
                prio_q[i] = '0;
                stamp_q[i] = '0;
            end
            level = '0;
            next_stamp = '0;
            errors = 0;
        endfunction

        function logic [PRIO_BITS_DEF-1:0] sat_sum(logic [PRIO_BITS_DEF-1:0] a,
                                                   logic [PRIO_BITS_DEF-1:0] b);
            logic [PRIO_BITS_DEF:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[PRIO_BITS_DEF] ? PRIO_MAX : s[PRIO_BITS_DEF-1:0];
        endfunction

        // Slot x has left priority old_p; move the level on if its group is now empty.
        function void leave_level(int x, logic [PRIO_BITS_DEF-1:0] old_p);
            bit any;
            logic [PRIO_BITS_DEF-1:0] least;
            any = 0;
            least = '0;
            if (old_p != level)
                return;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (i == x || !valid_q[i])
                    continue;
                if (prio_q[i] == level)
                    return;
                if (!any || prio_q[i] < least)
                begin
                    least = prio_q[i];
                    any = 1;
                end
            end
            if (any)
                level = least;
        endfunction

        function void note_request(req_item_t r);
            int found;
            int free_slot;
            int slot;
            int v;
            logic [PRIO_BITS_DEF-1:0] vp;
            logic [PRIO_BITS_DEF-1:0] np;
            logic [STAMP_W-1:0] va;
            logic [STAMP_W-1:0] a;
            rsp_item_t e;
            found = -1;
            free_slot = -1;
            e = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (valid_q[i] && key_q[i] == r.key)
                begin
                    if (found < 0)
                        found = i;
                end
                else if (!valid_q[i] && free_slot < 0)
                    free_slot = i;
            end
            if (r.action == ACT_REMOVE)
            begin
                if (found >= 0)
                begin
                    e.hit = 1'b1;
                    valid_q[found] = 0;
                    leave_level(found, prio_q[found]);
                end
            end
            else if (found >= 0)
            begin
                np = sat_sum(prio_q[found], level);
                e.hit = 1'b1;
                if (np != prio_q[found])
                    leave_level(found, prio_q[found]);
                prio_q[found] = np;
                stamp_q[found] = next_stamp++;
            end
            else
            begin
                slot = free_slot;
                if (slot < 0)
                begin
                    // Full table: lowest priority loses, the oldest among equals.
                    v = 0;
                    vp = prio_q[0];
                    va = next_stamp - stamp_q[0];
                    for (int i = 1; i < NUM_SLOTS; i++)
                    begin
                        a = next_stamp - stamp_q[i];
                        if (prio_q[i] < vp || (prio_q[i] == vp && a > va))
                        begin
                            v = i;
                            vp = prio_q[i];
                            va = a;
                        end
                    end
                    e.evicted = 1'b1;
                    e.evicted_key = key_q[v];
                    valid_q[v] = 0;
                    level = vp;
                    leave_level(v, vp);
                    slot = v;
                end
                valid_q[slot] = 1;
                key_q[slot] = r.key;
                prio_q[slot] = sat_sum(level, 1);
                stamp_q[slot] = next_stamp++;
            end
            owed_rsp.push_back(e);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t e;
            if (owed_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: %p", got);
                errors++;
                return;
            end
            e = owed_rsp.pop_front();
            if (got.hit !== e.hit)
            begin
                $error("hit: expected %0d, got %0d", e.hit, got.hit);
                errors++;
            end
            if (got.evicted !== e.evicted)
            begin
                $error("evicted: expected %0d, got %0d", e.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== e.evicted_key)
            begin
                $error("evicted_key: expected %h, got %h", e.evicted_key, got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    lfuda_replacement_policy u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lfuda_scoreboard board;
    // When set, neither side idles: the stretch of full-rate traffic.
    bit busy_phase;
    int idle_cycles;
    // A small pool of keys keeps hits, removes and evictions frequent.
    logic [KEY_W-1:0] key_pool[40];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every accepted request is noted at the edge it is taken; every accepted
    // response is checked at the edge it is taken. The watchdog counts edges
    // at which nothing moved.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // The response side stalls now and then, except in the busy stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= !busy_phase && ($urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL lfuda_replacement_policy");
            $finish;
        end
    end

    // Present one item and hold it until it is taken; an idle gap may come first.
    task automatic send_item(input logic act, input logic [KEY_W-1:0] k);
        if (!busy_phase)
        begin
            while ($urandom_range(99) < 9)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req.action <= act;
        req.key <= k;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(9) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(39)];
    endfunction

    initial
    begin
        logic [KEY_W-1:0] ones;
        ones = '1;
        board = new();
        board.clear_table();
        busy_phase = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        for (int i = 0; i < 40; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = ones;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: the extreme keys, a remove of an absent key, a hit,
        // a fill past capacity that forces evictions, then a remove of the
        // last key inserted.
        send_item(ACT_REMOVE, ones);
        send_item(ACT_ACCESS, '0);
        send_item(ACT_ACCESS, ones);
        send_item(ACT_ACCESS, '0);
        send_item(ACT_REMOVE, '0);
        for (int i = 0; i < NUM_SLOTS + 3; i++)
            send_item(ACT_ACCESS, 64'h100 + i);
        send_item(ACT_REMOVE, 64'h100 + NUM_SLOTS + 2);
        pause_sender();

        // Random part; a stretch in the middle runs without idling.
        for (int n = 0; n < 750; n++)
        begin
            busy_phase = (n >= 250 && n < 400);
            if (n == 500)
                pause_sender();
            send_item(($urandom_range(99) < 25) ? ACT_REMOVE : ACT_ACCESS, pick_key());
        end
        busy_phase = 1'b0;
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.owed_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * NUM_SLOTS + 10) @(posedge clk);
        if (board.errors == 0)
            $display("PASS lfuda_replacement_policy");
        else
            $display("FAIL lfuda_replacement_policy");
        $finish;
    end

endmodule

// ----- lfuda_replacement_policy.f -----
src/lfuda_pkg.sv
src/lfuda_ram.sv
src/lfuda_ctrl.sv
src/lfuda_dp.sv
src/lfuda_replacement_policy.sv
dv/lfuda_replacement_policy_test.sv
